[sv/mssr_pkg.sv]
// ----------------------------------------------------------------------------
// mssr_pkg: shared types and constants for the servo setpoint ramp unit
// Channel table sizing, fixed-point widths, item and result word layouts.
// ----------------------------------------------------------------------------
package mssr_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int FRAC_BITS    = 6;
	localparam int POS_BITS     = 12;
	localparam int SP_BITS      = POS_BITS + FRAC_BITS;
	localparam int IDX_BITS     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_BITS     = $clog2(MAX_CHANNELS + 1);

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_DUP   = 2'd2;
	localparam logic [1:0] ST_GOAL  = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  servo_id;
		logic [11:0] target_position;
		logic [11:0] measured_position;
		logic [15:0] move_ms;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_id;
		logic [11:0] goal_position;
		logic [4:0]  channel_count;
		logic        last;
	} out_word_t;

	// divider handshake
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
	} div_sts_t;

endpackage

[sv/mssr_div.sv]
// ----------------------------------------------------------------------------
// mssr_div: restoring divider, one quotient bit per cycle
// 32-bit dividend by 32-bit divisor, quotient only.
// ----------------------------------------------------------------------------
module mssr_div import mssr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output div_sts_t    sts,
	output logic [31:0] quotient
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

[sv/multi_servo_setpoint_ramp_unit.sv]
// ----------------------------------------------------------------------------
// multi_servo_setpoint_ramp_unit: multi-channel linear setpoint ramp generator
// Add: serial id search. Start: the same search, then two serial divides
// when the id is found. Tick: walks every registered channel and emits a
// goal word per due running channel (each is held until the next one or
// the end of the sweep settles its last flag). One word in flight at a time;
// the channel table is walked serially and one serial divider is shared.
// Reset clears the table (count, running flags) and sets frame delay to 33.
// ----------------------------------------------------------------------------
module multi_servo_setpoint_ramp_unit import mssr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_data,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SRCH  = 8'b0000_0010,
		S_DIV1  = 8'b0000_0100,
		S_DIV2  = 8'b0000_1000,
		S_WRST  = 8'b0001_0000,
		S_TICK  = 8'b0010_0000,
		S_EMIT  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [9:0]          delay_q;
	logic [CNT_BITS-1:0] used_q;
	logic [CNT_BITS-1:0] idx_q;
	in_word_t            item_q;
	logic                emitted_q;
	logic                out_valid_q;
	out_word_t           out_q;
	logic                div_go_q;

	logic [7:0]         id_mem   [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] run_q;
	logic [SP_BITS-1:0] sp_mem   [MAX_CHANNELS];
	logic [SP_BITS-1:0] tg_mem   [MAX_CHANNELS];
	logic [SP_BITS-1:0] stp_mem  [MAX_CHANNELS];
	logic [31:0]        lf_mem   [MAX_CHANNELS];

	logic [IDX_BITS-1:0] ix;
	logic [9:0]          eff_delay;
	logic [SP_BITS-1:0]  cur_in, nxt_in, dist_in;
	logic [31:0]         frames_q;
	logic [31:0]         div_a, div_b, quo;
	div_req_t            dreq;
	div_sts_t            dsts;
	logic [SP_BITS-1:0]  cur, nxt, stp, gap, new_sp;
	logic                up, snap;
	logic                due;
	logic                out_free;

	assign ix        = idx_q[IDX_BITS-1:0];
	assign eff_delay = (delay_q == '0) ? 10'd1 : delay_q;
	assign cur_in    = {item_q.measured_position[POS_BITS-1:0], FRAC_BITS'(0)};
	assign nxt_in    = {item_q.target_position[POS_BITS-1:0], FRAC_BITS'(0)};
	assign dist_in   = (nxt_in > cur_in) ? nxt_in - cur_in : cur_in - nxt_in;

	assign div_a = state_q == S_DIV1 ? {16'd0, item_q.move_ms} : 32'(dist_in);
	assign div_b = state_q == S_DIV1 ? {22'd0, eff_delay} : frames_q;
	assign dreq.start = div_go_q;

	mssr_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .dividend(div_a), .divisor(div_b),
		.sts(dsts), .quotient(quo)
	);

	assign cur    = sp_mem[ix];
	assign nxt    = tg_mem[ix];
	assign stp    = stp_mem[ix];
	assign up     = nxt > cur;
	assign gap    = up ? nxt - cur : cur - nxt;
	assign snap   = gap < stp;
	assign new_sp = snap ? nxt : (up ? cur + stp : cur - stp);
	assign due    = (item_q.now_ms - lf_mem[ix]) >= {22'd0, eff_delay};

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= 10'd33;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			idx_q       <= '0;
			run_q       <= '0;
			emitted_q   <= 1'b0;
			out_valid_q <= 1'b0;
			div_go_q    <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q     <= '0;
						emitted_q <= 1'b0;
						if (in_data.kind == KIND_ADD || in_data.kind == KIND_START)
							state_q <= S_SRCH;
						else if (in_data.kind == KIND_TICK)
							state_q <= S_TICK;
					end
				end
				S_SRCH: begin
					if (idx_q < used_q && id_mem[ix] != item_q.servo_id) begin
						idx_q <= idx_q + 1'b1;
					end else if (item_q.kind == KIND_START) begin
						if (idx_q < used_q) begin
							div_go_q <= 1'b1;
							state_q  <= S_DIV1;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (out_free) begin
						out_valid_q           <= 1'b1;
						out_q.out_id          <= item_q.servo_id;
						out_q.goal_position   <= '0;
						out_q.last            <= 1'b1;
						out_q.channel_count   <= 5'(used_q);
						if (used_q >= CNT_BITS'(MAX_CHANNELS)) begin
							out_q.status <= ST_FULL;
						end else if (idx_q < used_q) begin
							out_q.status <= ST_DUP;
						end else begin
							out_q.status        <= ST_ADDED;
							out_q.channel_count <= 5'(used_q + 1'b1);
							run_q[ix]           <= 1'b0;
							used_q              <= used_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_DIV1: begin
					if (!div_go_q && !dsts.busy) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (!div_go_q && !dsts.busy)
						state_q <= S_WRST;
				end
				S_WRST: begin
					run_q[ix] <= 1'b1;
					state_q   <= S_IDLE;
				end
				S_TICK: begin
					if (idx_q >= used_q) begin
						state_q <= S_DONE;
					end else if (due && run_q[ix]) begin
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (emitted_q) begin
						// another goal word follows, so the held one is not last
						out_valid_q <= 1'b1;
						emitted_q   <= 1'b0;
					end else if (out_free) begin
						if (cur == nxt || snap)
							run_q[ix] <= 1'b0;
						out_q.status        <= ST_GOAL;
						out_q.out_id        <= id_mem[ix];
						out_q.goal_position <= 12'(new_sp >> FRAC_BITS);
						out_q.channel_count <= '0;
						out_q.last          <= 1'b0;
						emitted_q           <= 1'b1;
						idx_q               <= idx_q + 1'b1;
						state_q             <= S_TICK;
					end
				end
				S_DONE: begin
					// the held goal word closes the sweep
					if (emitted_q) begin
						out_valid_q <= 1'b1;
						out_q.last  <= 1'b1;
						emitted_q   <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			item_q <= in_data;
		if (state_q == S_DIV1 && !div_go_q && !dsts.busy)
			frames_q <= quo + 32'd1;
		if (state_q == S_SRCH && item_q.kind == KIND_ADD && idx_q >= used_q
				&& used_q < CNT_BITS'(MAX_CHANNELS) && out_free)
			id_mem[ix] <= item_q.servo_id;
		if (state_q == S_WRST) begin
			sp_mem[ix]  <= cur_in;
			tg_mem[ix]  <= nxt_in;
			lf_mem[ix]  <= item_q.now_ms;
			stp_mem[ix] <= SP_BITS'(quo + 32'd1);
		end
		if (state_q == S_TICK && idx_q < used_q && due)
			lf_mem[ix] <= item_q.now_ms;
		if (state_q == S_EMIT && !emitted_q && out_free)
			sp_mem[ix] <= new_sp;
	end

endmodule
